// ----- sv/lac_pkg.sv -----
package lac_pkg;

  // Frame store geometry.
  localparam int STORE_WIDTH  = 256;
  localparam int STORE_HEIGHT = 256;
  localparam int DEPTH        = STORE_WIDTH * STORE_HEIGHT;
  localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [31:0]       pix_t;
  typedef logic [15:0]       prod_t;

  // Item kinds.
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_BLEND = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic CFG_CANVAS_HEIGHT = 1'b1;

  localparam logic [8:0] CANVAS_RESET = 9'd256;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        source_x;
    logic [7:0]        source_y;
    logic signed [8:0] offset_x;
    logic signed [8:0] offset_y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       in_range;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic mul_en;
    logic wr_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_kind;
    logic       loc_on;
    logic       clr_last;
    logic       out_free;
  } stat_t;

  // Truncating division by 255 for products of two 8-bit values.
  function automatic logic [7:0] div255(input prod_t x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ----- sv/lac_in_if.sv -----
interface lac_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        source_x;
  logic [7:0]        source_y;
  logic signed [8:0] offset_x;
  logic signed [8:0] offset_y;
  logic [7:0]        in_red;
  logic [7:0]        in_green;
  logic [7:0]        in_blue;
  logic [7:0]        in_alpha;

  modport source (
    output valid, kind, source_x, source_y, offset_x, offset_y,
           in_red, in_green, in_blue, in_alpha,
    input  ready
  );
  modport sink (
    input  valid, kind, source_x, source_y, offset_x, offset_y,
           in_red, in_green, in_blue, in_alpha,
    output ready
  );
endinterface

// ----- sv/lac_out_if.sv -----
interface lac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       in_range;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, in_range,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, in_range,
    output ready
  );
endinterface

// ----- sv/lac_datapath.sv -----
module lac_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_wdata,
  input  lac_pkg::in_item_t in_item,
  input  logic              out_ready,
  input  lac_pkg::cmd_t     cmd,
  output lac_pkg::stat_t    stat,
  output logic              out_valid,
  output lac_pkg::out_item_t out_item
);

  logic [8:0]          width_r;
  logic [8:0]          height_r;
  logic                on_r;
  lac_pkg::addr_t      addr_r;
  logic [31:0]         src_r;
  lac_pkg::pix_t       rdata_r;
  lac_pkg::prod_t      prod_r [4];
  lac_pkg::addr_t      clr_cnt_r;
  logic                out_valid_r;
  lac_pkg::out_item_t  out_r;

  lac_pkg::pix_t       mem [lac_pkg::DEPTH];

  logic signed [9:0]   dx;
  logic signed [9:0]   dy;
  logic                loc_on;
  lac_pkg::addr_t      loc_addr;
  logic [7:0]          inv;
  lac_pkg::pix_t       blend_pix;
  logic                mem_we;
  lac_pkg::addr_t      mem_waddr;
  lac_pkg::pix_t       mem_wdata;

  // Canvas position of the incoming item.
  always_comb begin
    dx = $signed({2'b00, in_item.source_x}) + {in_item.offset_x[8], in_item.offset_x};
    dy = $signed({2'b00, in_item.source_y}) + {in_item.offset_y[8], in_item.offset_y};
    loc_on = !dx[9] && !dy[9] &&
             (dx[8:0] < width_r)  && (32'(dx[8:0]) < 32'(lac_pkg::STORE_WIDTH)) &&
             (dy[8:0] < height_r) && (32'(dy[8:0]) < 32'(lac_pkg::STORE_HEIGHT));
    loc_addr = lac_pkg::addr_t'(dy[8:0]) * lac_pkg::addr_t'(lac_pkg::STORE_WIDTH) +
               lac_pkg::addr_t'(dx[8:0]);
  end

  assign inv = lac_pkg::ALPHA_OPAQUE - src_r[31:24];

  always_comb begin
    if (src_r[31:24] == lac_pkg::ALPHA_OPAQUE) begin
      blend_pix = src_r;
    end else if (src_r[31:24] == lac_pkg::ALPHA_CLEAR) begin
      blend_pix = rdata_r;
    end else begin
      blend_pix = {src_r[31:24] + lac_pkg::div255(prod_r[3]),
                   lac_pkg::div255(prod_r[2]),
                   lac_pkg::div255(prod_r[1]),
                   lac_pkg::div255(prod_r[0])};
    end
  end

  always_comb begin
    mem_we    = cmd.clr_step || cmd.wr_en;
    mem_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
    mem_wdata = cmd.clr_step ? '0 : blend_pix;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= lac_pkg::CANVAS_RESET;
      height_r    <= lac_pkg::CANVAS_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      on_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lac_pkg::CFG_CANVAS_WIDTH:  width_r  <= cfg_wdata;
          lac_pkg::CFG_CANVAS_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + lac_pkg::addr_t'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        on_r <= loc_on;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= loc_addr;
      src_r  <= {in_item.alpha, in_item.blue, in_item.green, in_item.red};
    end
    if (cmd.mul_en) begin
      prod_r[0] <= 16'(src_r[7:0])   * 16'(src_r[31:24]) + 16'(rdata_r[7:0])   * 16'(inv);
      prod_r[1] <= 16'(src_r[15:8])  * 16'(src_r[31:24]) + 16'(rdata_r[15:8])  * 16'(inv);
      prod_r[2] <= 16'(src_r[23:16]) * 16'(src_r[31:24]) + 16'(rdata_r[23:16]) * 16'(inv);
      prod_r[3] <= 16'(rdata_r[31:24]) * 16'(inv);
    end
    if (cmd.out_load) begin
      out_r.red      <= on_r ? rdata_r[7:0]   : 8'd0;
      out_r.green    <= on_r ? rdata_r[15:8]  : 8'd0;
      out_r.blue     <= on_r ? rdata_r[23:16] : 8'd0;
      out_r.alpha    <= on_r ? rdata_r[31:24] : 8'd0;
      out_r.in_range <= on_r;
    end
  end

  always_comb begin
    stat.in_kind  = in_item.kind;
    stat.loc_on   = loc_on;
    stat.clr_last = (clr_cnt_r == lac_pkg::addr_t'(lac_pkg::DEPTH - 1));
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- sv/lac_ctrl.sv -----
module lac_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  lac_pkg::stat_t stat,
  output logic           in_ready,
  output lac_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_BL_READ,
    ST_BL_MUL,
    ST_BL_WRITE,
    ST_RD_READ,
    ST_RD_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.in_kind)
            lac_pkg::KIND_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            lac_pkg::KIND_BLEND: state_nxt = stat.loc_on ? ST_BL_READ : ST_IDLE;
            lac_pkg::KIND_READ:  state_nxt = stat.loc_on ? ST_RD_READ : ST_RD_RESULT;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BL_READ:  state_nxt = ST_BL_MUL;
      ST_BL_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_BL_WRITE;
      end
      ST_BL_WRITE: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD_READ:  state_nxt = ST_RD_RESULT;
      ST_RD_RESULT: begin
        // Wait here until the output register can take the word.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/layer_alpha_compositor.sv -----
// Layer compositor over an RGBA8 canvas held in an on-chip frame store.
// Items arrive on in_chan (valid/ready); a word is taken when both are high.
// A clear word zeroes the whole store, a blend word places one source pixel
// at source plus offset and blends it over the canvas, a read word returns
// the canvas pixel and an in-range flag on out_chan. Canvas width and height
// are written through cfg_we/cfg_index/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it. Each
// item follows the registered store read, multiply and write-back steps:
// a blend word on canvas reads, multiplies and writes back, and off canvas
// is dropped; a read word on canvas reads the store and loads the result,
// off canvas loads zeros with no store read; a clear word zeroes the store,
// one store entry per cycle. After reset the block likewise sweeps the
// store to transparent black, ready low, taking configuration writes.
// The result sits in an output register: new items are taken while it waits,
// and a read item that finishes while out_chan is stalled holds until the
// register frees up.
module layer_alpha_compositor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  lac_in_if.sink     in_chan,
  lac_out_if.source  out_chan
);

  lac_pkg::in_item_t  in_item;
  lac_pkg::out_item_t out_item;
  lac_pkg::cmd_t      cmd;
  lac_pkg::stat_t     stat;
  logic               in_ready;
  logic               out_valid;

  always_comb begin
    in_item.kind     = in_chan.kind;
    in_item.source_x = in_chan.source_x;
    in_item.source_y = in_chan.source_y;
    in_item.offset_x = in_chan.offset_x;
    in_item.offset_y = in_chan.offset_y;
    in_item.red      = in_chan.in_red;
    in_item.green    = in_chan.in_green;
    in_item.blue     = in_chan.in_blue;
    in_item.alpha    = in_chan.in_alpha;
  end

  lac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lac_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid;
  assign out_chan.out_red   = out_item.red;
  assign out_chan.out_green = out_item.green;
  assign out_chan.out_blue  = out_item.blue;
  assign out_chan.out_alpha = out_item.alpha;
  assign out_chan.in_range  = out_item.in_range;

endmodule
